@@ rtl/assert_macros.svh @@
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, disabled while reset is low.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

@@ rtl/vdi_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package vdi_pkg;

  // Table geometry
  localparam int MAX_VERTICES = 256;
  localparam int IDX_W        = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int COMP_W       = 32;
  localparam int NUM_COMPS    = 3;
  localparam int ENTRY_W      = COMP_W * NUM_COMPS;
  localparam int OUT_IDX_W    = 8;

  // Command codes
  localparam logic CMD_CLEAR  = 1'b0;
  localparam logic CMD_VERTEX = 1'b1;

  // One stored vertex: {x, y, z}
  typedef logic [ENTRY_W-1:0] entry_t;

endpackage

`default_nettype wire

@@ rtl/vdi_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

// One slot of the rotating vertex table: takes its neighbor's entry every
// cycle, or a new vertex when the load strobe is set.
module vdi_cell
  import vdi_pkg::*;
(
  input  wire    clk_i,
  input  entry_t shift_i,
  input  wire    load_i,
  input  entry_t load_data_i,
  output entry_t entry_o
);

  entry_t entry_q;
  entry_t entry_d;

  // next entry: neighbor data or inserted vertex
  always_comb begin
    entry_d = load_i ? load_data_i : shift_i;
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

@@ rtl/vdi_ring.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Ring of table cells. Cell k holds logical entry (k + offset) mod depth;
// every cycle each cell takes the one above it, the last takes the head or the loaded vertex.
module vdi_ring
  import vdi_pkg::*;
(
  input  wire    clk_i,
  input  wire    load_i,
  input  entry_t load_data_i,
  output entry_t head_o
);

  entry_t entries [MAX_VERTICES];

  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    if (k == MAX_VERTICES - 1) begin : g_tail
      // tail wraps the head around, or takes the inserted vertex
      vdi_cell u_cell (
        .clk_i       (clk_i),
        .shift_i     (entries[0]),
        .load_i      (load_i),
        .load_data_i (load_data_i),
        .entry_o     (entries[k])
      );
    end else begin : g_body
      vdi_cell u_cell (
        .clk_i       (clk_i),
        .shift_i     (entries[k+1]),
        .load_i      (1'b0),
        .load_data_i (load_data_i),
        .entry_o     (entries[k])
      );
    end
  end

  assign head_o = entries[0];

endmodule

`default_nettype wire

@@ rtl/vertex_dedup_indexer.sv @@
// Vertex lookup: the scan covers all MAX_VERTICES slots as the table rotates once past the
// head comparator; the result strobe follows in the next cycle. Clear: strobe next cycle.
// A new vertex is taken only after the last scan ends, as there is a single compare port
// at the ring head; start may be raised again in the cycle of the strobe.
// Reset clears the entry count and control; table contents stay undefined until written.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module vertex_dedup_indexer
  import vdi_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start,
  output logic                 busy,
  input  wire                  command_i,
  input  wire  [COMP_W-1:0]    comp_x_i,
  input  wire  [COMP_W-1:0]    comp_y_i,
  input  wire  [COMP_W-1:0]    comp_z_i,
  output logic                 result_valid_o,
  output logic [OUT_IDX_W-1:0] vertex_index_o,
  output logic                 is_new_o,
  output logic                 overflow_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  state_e               state_q, state_d;
  logic [IDX_W-1:0]     scan_q, scan_d;
  logic [IDX_W-1:0]     off_q, off_d;
  logic [CNT_W-1:0]     count_q, count_d;
  entry_t               query_q, query_d;
  logic                 hit_q, hit_d;
  logic [IDX_W-1:0]     hit_idx_q, hit_idx_d;
  logic                 valid_q, valid_d;
  logic [OUT_IDX_W-1:0] index_q, index_d;
  logic                 is_new_q, is_new_d;
  logic                 ovf_q, ovf_d;

  entry_t               head;
  logic                 scanning;
  logic                 accept;
  logic                 head_valid;
  logic                 head_match;
  logic                 hit_now;
  logic [IDX_W-1:0]     idx_now;
  logic                 ring_load;
  logic                 scan_last;
  logic                 full;

  // rotating table
  vdi_ring u_ring (
    .clk_i       (clk_i),
    .load_i      (ring_load),
    .load_data_i (query_q),
    .head_o      (head)
  );

  // head compare and insert slot detection
  always_comb begin
    scanning   = (state_q == ST_SCAN);
    accept     = start && !scanning;
    head_valid = CNT_W'(off_q) < count_q;
    head_match = scanning && head_valid && (head == query_q);
    hit_now    = hit_q || head_match;
    idx_now    = hit_q ? hit_idx_q : off_q;
    ring_load  = scanning && (CNT_W'(off_q) == count_q);
    scan_last  = (scan_q == IDX_W'(MAX_VERTICES - 1));
    full       = (count_q == CNT_W'(MAX_VERTICES));
  end

  // ring offset wraps at table depth
  always_comb begin
    if (off_q == IDX_W'(MAX_VERTICES - 1)) begin
      off_d = '0;
    end else begin
      off_d = off_q + 1'b1;
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    scan_d    = scan_q;
    count_d   = count_q;
    query_d   = query_q;
    hit_d     = hit_q;
    hit_idx_d = hit_idx_q;
    valid_d   = 1'b0;
    index_d   = index_q;
    is_new_d  = is_new_q;
    ovf_d     = ovf_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (command_i == CMD_CLEAR) begin
            count_d  = '0;
            valid_d  = 1'b1;
            index_d  = '0;
            is_new_d = 1'b0;
            ovf_d    = 1'b0;
          end else begin
            query_d = {comp_x_i, comp_y_i, comp_z_i};
            scan_d  = '0;
            hit_d   = 1'b0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        hit_d     = hit_now;
        hit_idx_d = idx_now;
        scan_d    = scan_q + 1'b1;
        if (scan_last) begin
          state_d = ST_IDLE;
          valid_d = 1'b1;
          if (hit_now) begin
            index_d  = OUT_IDX_W'(idx_now);
            is_new_d = 1'b0;
            ovf_d    = 1'b0;
          end else if (full) begin
            index_d  = '0;
            is_new_d = 1'b0;
            ovf_d    = 1'b1;
          end else begin
            index_d  = OUT_IDX_W'(count_q);
            is_new_d = 1'b1;
            ovf_d    = 1'b0;
            count_d  = count_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      scan_q  <= '0;
      off_q   <= '0;
      count_q <= '0;
      hit_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      off_q   <= off_d;
      count_q <= count_d;
      hit_q   <= hit_d;
      valid_q <= valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    query_q   <= query_d;
    hit_idx_q <= hit_idx_d;
    index_q   <= index_d;
    is_new_q  <= is_new_d;
    ovf_q     <= ovf_d;
  end

  assign busy           = scanning;
  assign result_valid_o = valid_q;
  assign vertex_index_o = index_q;
  assign is_new_o       = is_new_q;
  assign overflow_o     = ovf_q;

  // checks
  `ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > CNT_W'(MAX_VERTICES), "count exceeds table depth")
  `ASSERT_NEVER(a_new_and_ovf, clk_i, rst_ni, valid_q && is_new_q && ovf_q, "new and overflow together")
  `ASSERT_CLK(a_strobe_idle, clk_i, rst_ni, valid_q |-> (state_q == ST_IDLE), "strobe while scanning")
  `ASSERT_CLK(a_new_counts, clk_i, rst_ni, (valid_q && is_new_q) |-> (count_q == CNT_W'($past(count_q) + 1'b1)), "append without count step")
  `ASSERT_CLK(a_vertex_scans, clk_i, rst_ni, (accept && (command_i == CMD_VERTEX)) |=> busy, "vertex transfer did not start a scan")

endmodule

`default_nettype wire

@@ test/vertex_dedup_indexer_test.sv @@
`timescale 1ns / 1ps

module vertex_dedup_indexer_test;
  import vdi_pkg::*;

  // One lookup answer as the block reports it
  typedef struct packed {
    logic [OUT_IDX_W-1:0] index;
    logic                 is_new;
    logic                 overflow;
  } lookup_result_t;

  localparam logic [COMP_W-1:0] FLOAT_SPECIALS [8] = '{
    32'h0000_0000, 32'h8000_0000, 32'h3f80_0000, 32'hbf80_0000,
    32'h7f80_0000, 32'hff80_0000, 32'h7fc0_0000, 32'h0000_0001
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic                 command_i;
  logic [COMP_W-1:0]    comp_x_i;
  logic [COMP_W-1:0]    comp_y_i;
  logic [COMP_W-1:0]    comp_z_i;
  logic                 result_valid_o;
  logic [OUT_IDX_W-1:0] vertex_index_o;
  logic                 is_new_o;
  logic                 overflow_o;

  // Predictor state: welded vertex table and its fill level
  entry_t         welded_table [MAX_VERTICES];
  int unsigned    welded_count = 0;
  lookup_result_t pending_lookups [$];
  entry_t         recent_vertices [$];

  int gap_pct = 0;
  int error_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int hits_predicted = 0;
  int overflows_predicted = 0;
  int clears_sent = 0;

  vertex_dedup_indexer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .comp_x_i       (comp_x_i),
    .comp_y_i       (comp_y_i),
    .comp_z_i       (comp_z_i),
    .result_valid_o (result_valid_o),
    .vertex_index_o (vertex_index_o),
    .is_new_o       (is_new_o),
    .overflow_o     (overflow_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Expected answer for one command; updates the predicted table
  function automatic lookup_result_t weld_vertex(logic cmd, logic [COMP_W-1:0] x,
                                                 logic [COMP_W-1:0] y,
                                                 logic [COMP_W-1:0] z);
    lookup_result_t res;
    entry_t         key;
    res = '0;
    key = {x, y, z};
    if (cmd == CMD_CLEAR) begin
      welded_count = 0;
      clears_sent++;
      return res;
    end
    // exact bit-pattern compare, lowest index first
    for (int i = 0; i < welded_count; i++) begin
      if (welded_table[i] == key) begin
        res.index = OUT_IDX_W'(i);
        hits_predicted++;
        return res;
      end
    end
    if (welded_count >= MAX_VERTICES) begin
      res.overflow = 1'b1;
      overflows_predicted++;
      return res;
    end
    welded_table[welded_count] = key;
    res.index  = OUT_IDX_W'(welded_count);
    res.is_new = 1'b1;
    welded_count++;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // Result checker: each strobe is compared with the oldest expectation
  always @(posedge clk_i) begin
    lookup_result_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_lookups.size() == 0) begin
        report_mismatch($sformatf("unexpected result idx=%0d new=%b ovf=%b",
                                  vertex_index_o, is_new_o, overflow_o));
      end else begin
        want = pending_lookups.pop_front();
        results_checked++;
        if (vertex_index_o !== want.index)
          report_mismatch($sformatf("vertex_index %0d, expected %0d",
                                    vertex_index_o, want.index));
        if (is_new_o !== want.is_new)
          report_mismatch($sformatf("is_new %b, expected %b", is_new_o, want.is_new));
        if (overflow_o !== want.overflow)
          report_mismatch($sformatf("overflow %b, expected %b", overflow_o, want.overflow));
      end
    end
  end

  // One command transfer: drive at the falling edge, hold until accepted
  task automatic send_item(input logic cmd, input logic [COMP_W-1:0] x,
                           input logic [COMP_W-1:0] y, input logic [COMP_W-1:0] z);
    lookup_result_t predicted;
    @(negedge clk_i);
    start     = 1'b1;
    command_i = cmd;
    comp_x_i  = x;
    comp_y_i  = y;
    comp_z_i  = z;
    do @(posedge clk_i); while (busy);
    predicted = weld_vertex(cmd, x, y, z);
    pending_lookups = {pending_lookups, predicted};
    items_sent++;
  endtask

  task automatic send_vertex(input entry_t v);
    recent_vertices = {recent_vertices, v};
    if (recent_vertices.size() > 64) void'(recent_vertices.pop_front());
    send_item(CMD_VERTEX, v[3*COMP_W-1:2*COMP_W], v[2*COMP_W-1:COMP_W], v[COMP_W-1:0]);
  endtask

  // Sender idle gap; mostly short, now and then long enough to span a whole scan
  task automatic pace();
    int cycles;
    if ($urandom_range(99) < gap_pct) begin
      cycles = ($urandom_range(7) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 4);
      @(negedge clk_i);
      start     = 1'b0;
      command_i = 1'($urandom_range(1));
      comp_x_i  = $urandom;
      comp_y_i  = $urandom;
      comp_z_i  = $urandom;
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  // Hold off the sender until every outstanding answer is back
  task automatic wait_all_results();
    @(negedge clk_i);
    start = 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [COMP_W-1:0] pick_component();
    if ($urandom_range(3) == 0) return FLOAT_SPECIALS[$urandom_range(7)];
    return $urandom;
  endfunction

  // Extremes, signed zeros, NaN patterns, clear behavior
  task automatic test_directed_welding();
    gap_pct = 0;
    send_item(CMD_CLEAR, '1, '1, '1);
    send_vertex({32'h0, 32'h0, 32'h0});
    send_vertex({32'h0, 32'h0, 32'h0});
    send_vertex({32'h8000_0000, 32'h0, 32'h0});
    send_vertex({32'h0, 32'h8000_0000, 32'h0});
    send_vertex({32'h0, 32'h0, 32'h8000_0000});
    send_vertex({32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
    send_vertex({32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
    send_vertex({32'h7fc0_0000, 32'h7fc0_0000, 32'h7fc0_0000});
    send_vertex({32'h7fc0_0001, 32'h7fc0_0000, 32'h7fc0_0000});
    send_vertex({32'h7fc0_0000, 32'h7fc0_0000, 32'h7fc0_0000});
    send_vertex({32'h3f80_0000, 32'h4000_0000, 32'h4040_0000});
    send_vertex({32'h4040_0000, 32'h4000_0000, 32'h3f80_0000});
    send_vertex({32'h8000_0000, 32'h0, 32'h0});
    send_vertex({32'ha5a5_a5a5, 32'h5a5a_5a5a, 32'ha5a5_a5a5});
    send_item(CMD_CLEAR, $urandom, $urandom, $urandom);
    // old entries must be gone after a clear
    send_vertex({32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
    send_vertex({32'h0, 32'h0, 32'h0});
    send_vertex({32'h5a5a_5a5a, 32'ha5a5_a5a5, 32'h5a5a_5a5a});
    wait_all_results();
  endtask

  // Fill every slot, hit the edges, then miss on a full table
  task automatic test_table_overflow();
    entry_t filled [MAX_VERTICES];
    entry_t v;
    gap_pct = 32;
    send_item(CMD_CLEAR, '0, '0, '0);
    for (int i = 0; i < MAX_VERTICES; i++) begin
      filled[i] = {32'($urandom), 32'($urandom), 24'($urandom), 8'(i)};
      pace();
      send_vertex(filled[i]);
    end
    send_vertex(filled[MAX_VERTICES-1]);
    send_vertex(filled[0]);
    send_vertex(filled[MAX_VERTICES/2]);
    wait_all_results();
    repeat (12) begin
      pace();
      if ($urandom_range(1) == 0) begin
        v = filled[$urandom_range(MAX_VERTICES-1)];
      end else begin
        v = {$urandom, $urandom, $urandom};
      end
      send_vertex(v);
    end
    send_item(CMD_CLEAR, $urandom, $urandom, $urandom);
    send_vertex(filled[5]);
    send_vertex(filled[MAX_VERTICES-1]);
    send_vertex(filled[5]);
    wait_all_results();
  endtask

  // Nearly half repeats of recent vertices, plus specials, fresh data and clears
  task automatic test_random_stream(input int count, input int pct);
    entry_t v;
    int     pick;
    gap_pct = pct;
    repeat (count) begin
      pace();
      pick = $urandom_range(99);
      if (pick < 3) begin
        send_item(CMD_CLEAR, $urandom, $urandom, $urandom);
      end else begin
        if (pick < 50 && recent_vertices.size() != 0) begin
          v = recent_vertices[$urandom_range(recent_vertices.size() - 1)];
        end else if (pick < 65) begin
          v = {pick_component(), pick_component(), pick_component()};
        end else begin
          v = {$urandom, $urandom, $urandom};
        end
        send_vertex(v);
      end
      if ($urandom_range(49) == 0) wait_all_results();
    end
    wait_all_results();
  endtask

  initial begin
    rst_ni    = 1'b0;
    start     = 1'b0;
    command_i = CMD_VERTEX;
    comp_x_i  = '0;
    comp_y_i  = '0;
    comp_z_i  = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_welding();
    test_table_overflow();
    test_random_stream(130, 0);
    test_random_stream(130, 59);
    test_random_stream(130, 32);

    // drain, then allow one full scan for any stray strobe
    wait_all_results();
    repeat (300) @(posedge clk_i);

    $display("Sent %0d commands (%0d clears), checked %0d answers.",
             items_sent, clears_sent, results_checked);
    $display("Predicted %0d table hits and %0d full-table misses; %0d errors.",
             hits_predicted, overflows_predicted, error_count);
    if (error_count == 0 && pending_lookups.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #25_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
